// ===== src/ffc_pkg.sv =====
// Package for the float format converter: mode codes and shared widths.
// No dependencies.
`default_nettype none
package ffc_pkg;
  localparam int unsigned ModeW = 4;
  localparam int unsigned WordW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_TO_F16     = 4'd0,
    MODE_FROM_F16   = 4'd1,
    MODE_TO_BF16    = 4'd2,
    MODE_FROM_BF16  = 4'd3,
    MODE_TO_E4FN    = 4'd4,
    MODE_FROM_E4FN  = 4'd5,
    MODE_TO_E4UZ    = 4'd6,
    MODE_FROM_E4UZ  = 4'd7,
    MODE_TO_E5      = 4'd8,
    MODE_FROM_E5    = 4'd9,
    MODE_TO_E5UZ    = 4'd10,
    MODE_FROM_E5UZ  = 4'd11
  } mode_e;

  localparam logic [31:0] F16RoundAdd = 32'hc8000fff;
  localparam logic [15:0] F16QNan     = 16'h7e00;
  localparam logic [15:0] F16Inf      = 16'h7c00;
  localparam logic [15:0] Bf16QNan    = 16'h7fc1;
  localparam logic [31:0] F32QNan     = 32'h7fc00000;
endpackage
`default_nettype wire

// ===== src/ffc_core.sv =====
// Combinational conversion datapath for all twelve modes.
// Depends on ffc_pkg.
`default_nettype none
module ffc_core (
  input  wire logic [ffc_pkg::ModeW-1:0] mode_i,
  input  wire logic [ffc_pkg::WordW-1:0] operand_i,
  output logic      [ffc_pkg::WordW-1:0] result_o
);
  import ffc_pkg::*;

  logic [31:0] abs_w, f16_sum, bf_sum, sub_sig, sub_q;
  logic [15:0] to_f16;
  logic [31:0] from_f16, from_bf16;
  logic [7:0]  exp32;
  logic [6:0]  sh;
  logic [31:0] sub_rem, sub_half;
  logic [4:0]  h_e;
  logic [9:0]  h_m;
  logic [3:0]  lz_k;
  logic [7:0]  e4_enc, e4uz_enc, e5_enc, e5uz_enc;
  logic [31:0] e4_dec, e5_dec;
  logic signed [9:0] e4_b, e5_b;

  // fp32 -> fp16
  always_comb begin
    abs_w    = {1'b0, operand_i[30:0]};
    exp32    = operand_i[30:23];
    sub_sig  = {8'd0, 1'b1, operand_i[22:0]};
    sh       = 7'(8'd126 - exp32);
    sub_q    = 32'd0;
    sub_rem  = 32'd0;
    sub_half = 32'd0;
    f16_sum  = abs_w + F16RoundAdd + {31'd0, abs_w[13]};
    to_f16   = 16'd0;
    if (abs_w >= {1'b0, 8'd143, 23'd0}) begin
      to_f16 = (abs_w > 32'h7f800000) ? F16QNan : F16Inf;
    end else if (abs_w < {1'b0, 8'd113, 23'd0}) begin
      if (exp32 != 8'd0 && sh <= 7'd24) begin
        sub_q    = sub_sig >> sh;
        sub_rem  = sub_sig & ((32'd1 << sh) - 32'd1);
        sub_half = 32'd1 << (sh - 7'd1);
        if (sub_rem > sub_half || (sub_rem == sub_half && sub_q[0])) begin
          sub_q = sub_q + 32'd1;
        end
        to_f16 = sub_q[15:0];
      end
    end else begin
      to_f16 = f16_sum[28:13];
    end
    to_f16 = to_f16 | {operand_i[31], 15'd0};
  end

  // fp16 -> fp32, subnormals renormalized by a leading-one search on 10 bits
  always_comb begin
    h_e  = operand_i[14:10];
    h_m  = operand_i[9:0];
    lz_k = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_m[i]) lz_k = 4'(i);
    end
    if (h_e == 5'd31) begin
      from_f16 = {1'b0, 8'hff, h_m, 13'd0};
    end else if (h_e == 5'd0) begin
      if (h_m == 10'd0) from_f16 = 32'd0;
      else from_f16 = {1'b0, 8'(8'd103 + {4'd0, lz_k}),
                       23'({13'd0, h_m} << (5'd23 - {1'b0, lz_k}))};
    end else begin
      from_f16 = {1'b0, 8'({3'd0, h_e} + 8'd112), h_m, 13'd0};
    end
    from_f16[31] = operand_i[15];
  end

  // bf16 both ways
  always_comb begin
    bf_sum    = operand_i + {31'd0, operand_i[16]} + 32'h7fff;
    from_bf16 = (operand_i[14:0] > 15'h7f80) ? F32QNan : {operand_i[15:0], 16'd0};
  end

  // fp8 encode: biased exponent relative to fp32 field
  always_comb begin
    e4_b = $signed({2'b0, exp32}) - 10'sd120;
    e5_b = $signed({2'b0, exp32}) - 10'sd112;
    if (e4_b <= 0) begin
      e4_enc   = {operand_i[31], 7'd0};
      e4uz_enc = {operand_i[31], 4'd1, 1'b0, operand_i[22:21]};
    end else if (e4_b >= 10'sd15) begin
      e4_enc   = {operand_i[31], 4'hf, 3'd0};
      e4uz_enc = e4_enc;
    end else begin
      e4_enc   = {operand_i[31], e4_b[3:0], operand_i[22:20]};
      e4uz_enc = e4_enc;
    end
    if (e5_b <= 0) begin
      e5_enc   = {operand_i[31], 7'd0};
      e5uz_enc = {operand_i[31], 5'd1, 1'b0, operand_i[22]};
    end else if (e5_b >= 10'sd31) begin
      e5_enc   = {operand_i[31], 5'h1f, 2'd0};
      e5uz_enc = e5_enc;
    end else begin
      e5_enc   = {operand_i[31], e5_b[4:0], operand_i[22:21]};
      e5uz_enc = e5_enc;
    end
  end

  // fp8 decode
  always_comb begin
    if (operand_i[6:3] == 4'd0) e4_dec = {operand_i[7], 31'd0};
    else e4_dec = {operand_i[7], 8'({4'd0, operand_i[6:3]} + 8'd120), operand_i[2:0], 20'd0};
    if (operand_i[6:2] == 5'd0) e5_dec = {operand_i[7], 31'd0};
    else e5_dec = {operand_i[7], 8'({3'd0, operand_i[6:2]} + 8'd112), operand_i[1:0], 21'd0};
  end

  always_comb begin
    case (mode_i)
      MODE_TO_F16:    result_o = {16'd0, to_f16};
      MODE_FROM_F16:  result_o = from_f16;
      MODE_TO_BF16:   result_o = (abs_w > 32'h7f800000) ? {16'd0, Bf16QNan}
                                                         : {16'd0, bf_sum[31:16]};
      MODE_FROM_BF16: result_o = from_bf16;
      MODE_TO_E4FN:   result_o = {24'd0, e4_enc};
      MODE_TO_E4UZ:   result_o = {24'd0, e4uz_enc};
      MODE_TO_E5:     result_o = {24'd0, e5_enc};
      MODE_TO_E5UZ:   result_o = {24'd0, e5uz_enc};
      MODE_FROM_E4FN, MODE_FROM_E4UZ: result_o = e4_dec;
      MODE_FROM_E5,   MODE_FROM_E5UZ: result_o = e5_dec;
      default:        result_o = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/float_format_converter.sv =====
// Float format converter: fp32 to/from fp16, bf16 and four fp8 formats.
// Input reg holds mode and operand; the result reg registers the ffc_core output.
// Throughput: one transfer per cycle unless the sink stalls; ffc_core sets the clock.
// Stalls propagate back through ready; both stages keep flowing when unblocked.
// Reset (rst_ni low, async) clears both valid flags; payload regs are not reset.
// Depends on ffc_pkg and ffc_core.
`default_nettype none
module float_format_converter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [ffc_pkg::ModeW-1:0]  mode_i,
  input  wire logic [ffc_pkg::WordW-1:0]  operand_bits_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [ffc_pkg::WordW-1:0]  result_bits_o
);
  import ffc_pkg::*;

  logic             s1_vld_q, s2_vld_q;
  logic [ModeW-1:0] mode_q;
  logic [WordW-1:0] opnd_q, res_q, res_d;
  logic             s1_adv, s2_ready;

  // result stage takes a new word when empty or when its word leaves now
  assign s2_ready    = !s2_vld_q || out_ready_i;
  assign s1_adv      = s1_vld_q && s2_ready;
  assign in_ready_o  = !s1_vld_q || s2_ready;
  assign out_valid_o = s2_vld_q;
  assign result_bits_o = res_q;

  ffc_core u_core (
    .mode_i    (mode_q),
    .operand_i (opnd_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_vld_q <= in_valid_i;
      if (s2_ready) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      opnd_q <= operand_bits_i;
    end
    if (s1_adv) res_q <= res_d;
  end

  // a held result must not change while the sink stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !out_ready_i |=> s2_vld_q && $stable(res_q))
    else $error("result changed under stall");
  // an accepted input reaches stage one
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_vld_q)
    else $error("accepted input lost");
  // stage one cannot be dropped while the result stage is full and stalled
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s2_vld_q && !out_ready_i |=> s1_vld_q && $stable(opnd_q))
    else $error("stage one overwritten");
endmodule
`default_nettype wire
